/* rtl/core/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sum-checked frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

   localparam int MAX_FRAME_DEF = 32;

   localparam logic [7:0] SOF_BYTE = 8'hFA;
   localparam logic [7:0] EOF_BYTE = 8'hFB;

   localparam logic KIND_PASS  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_EMIT_RD,
      ST_EMIT_WR,
      ST_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic       frame_end;
      logic       kind;
      logic [7:0] data;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic flush;
   } stage_ctl_type;

   typedef struct packed {
      logic push_ok;
      logic flush_done;
   } stage_sts_type;

endpackage

`default_nettype wire

/* rtl/core/sfd_rsp_stage.sv */
// ----------------------------------------------------------------------------
// sfd_rsp_stage
// Result holding stage: keeps one pending result until the next one (or the
// end of the input byte's work) tells whether it was the last, then moves it
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_rsp_stage
   import sfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_ctl_type ctl,
   input  wire rsp_item_type  item,
   output stage_sts_type      sts,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata,   // [7:0] data
   output logic [1:0]         rsp_tuser,   // [0] kind, [1] frame_end
   output logic               rsp_tlast    // run_last
);

   logic         pend_valid_ff, pend_valid_in;
   rsp_item_type pend_ff, pend_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff, out_in;
   logic         out_last_ff, out_last_in;
   logic         out_free;
   logic         move;

   assign out_free = !out_valid_ff || rsp_tready;
   assign move     = pend_valid_ff && out_free && (ctl.push || ctl.flush);

   assign sts.push_ok    = !pend_valid_ff || out_free;
   assign sts.flush_done = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (move) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_last_in   = ctl.flush && !ctl.push;
         pend_valid_in = 1'b0;
      end
      if (ctl.push && sts.push_ok) begin
         pend_valid_in = 1'b1;
         pend_in       = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tuser  = {out_ff.frame_end, out_ff.kind};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

/* rtl/core/sum_checked_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// sum_checked_frame_deframer_core
// Deframer for 0xFA / 0xFB framed packets with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
//   channel | dir | tdata          | tuser                    | tlast
//   req     | in  | [7:0] rx_byte  | -                        | -
//   rsp     | out | [7:0] data     | [0] kind, [1] frame_end  | run_last
//
// Operation: one transaction per input byte. The byte is accepted; then each
// byte taken from the ring is read from memory and then decoded, and the byte's
// work closes with an empty check, then a flush of the last result. A good
// frame adds a read and a give-out for each payload/checksum byte; a rejected
// frame rescans its held bytes, and nested starts can fail in turn. The ring's
// single read port sets this pace. Reset is synchronous and empties the ring
// at once; no clearing pass. rsp stalls hold the walk; req_tready is low while a
// byte works.
// ----------------------------------------------------------------------------
`default_nettype none

module sum_checked_frame_deframer_core
   import sfd_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] data
   output logic [1:0]      rsp_tuser,    // [0] kind, [1] frame_end
   output logic            rsp_tlast     // run_last
);

   // The ring holds the open frame's bytes [base, split) followed directly by
   // the bytes still to be scanned [split, tail). A rejected frame passes its
   // start byte through, pulls split back to base: exactly the rescan order.
   localparam int RING_AW    = $clog2(MAX_FRAME + 1);
   localparam int RING_DEPTH = 1 << RING_AW;
   localparam int FILL_W     = $clog2(MAX_FRAME + 1);

   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] rd_data_ff;
   logic       rd_en;
   logic [RING_AW-1:0] rd_addr;
   logic       wr_en;

   seq_state_type state_ff, state_in;
   logic [RING_AW-1:0] base_ff, base_in;
   logic [RING_AW-1:0] split_ff, split_in;
   logic [RING_AW-1:0] tail_ff, tail_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [7:0]         sum_ff, sum_in;     // sum of stored bytes after start
   logic [7:0]         last_ff, last_in;   // newest stored byte
   logic [RING_AW-1:0] emit_ptr_ff, emit_ptr_in;
   logic [RING_AW-1:0] emit_end_ff, emit_end_in;

   stage_ctl_type stage_ctl;
   stage_sts_type stage_sts;
   rsp_item_type  item;

   logic check_ok;

   assign check_ok = (fill_ff >= FILL_W'(2)) && ((sum_ff - last_ff) == last_ff);
   assign wr_en    = req_tvalid && req_tready;

   // ring memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[tail_ff] <= req_tdata;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      split_in    = split_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      last_in     = last_ff;
      emit_ptr_in = emit_ptr_ff;
      emit_end_in = emit_end_ff;
      req_tready  = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = split_ff;
      stage_ctl   = '0;
      item        = '{frame_end: 1'b0, kind: KIND_PASS, data: SOF_BYTE};

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               tail_in  = tail_ff + RING_AW'(1);
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            if (split_ff == tail_ff) begin
               state_in = ST_FLUSH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = split_ff;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (fill_ff == '0) begin
               // hunting: open a frame or pass the byte through
               if (rd_data_ff == SOF_BYTE) begin
                  fill_in  = FILL_W'(1);
                  split_in = split_ff + RING_AW'(1);
                  sum_in   = '0;
                  state_in = ST_READ;
               end else begin
                  stage_ctl.push = 1'b1;
                  item = '{frame_end: 1'b0, kind: KIND_PASS, data: rd_data_ff};
                  if (stage_sts.push_ok) begin
                     base_in  = base_ff + RING_AW'(1);
                     split_in = split_ff + RING_AW'(1);
                     state_in = ST_READ;
                  end
               end
            end else if (rd_data_ff == EOF_BYTE && fill_ff < FILL_W'(MAX_FRAME)) begin
               if (check_ok) begin
                  split_in    = split_ff + RING_AW'(1);
                  fill_in     = fill_ff + FILL_W'(1);
                  emit_ptr_in = base_ff + RING_AW'(1);
                  emit_end_in = base_ff + RING_AW'(fill_ff) - RING_AW'(1);
                  state_in    = ST_EMIT_RD;
               end else begin
                  // bad sum: end byte joins the rescan
                  stage_ctl.push = 1'b1;
                  if (stage_sts.push_ok) begin
                     base_in  = base_ff + RING_AW'(1);
                     split_in = base_ff + RING_AW'(1);
                     fill_in  = '0;
                     state_in = ST_READ;
                  end
               end
            end else if (fill_ff >= FILL_W'(MAX_FRAME)) begin
               // overflow: current byte stays queued behind the held bytes
               stage_ctl.push = 1'b1;
               if (stage_sts.push_ok) begin
                  base_in  = base_ff + RING_AW'(1);
                  split_in = base_ff + RING_AW'(1);
                  fill_in  = '0;
                  state_in = ST_READ;
               end
            end else begin
               split_in = split_ff + RING_AW'(1);
               fill_in  = fill_ff + FILL_W'(1);
               sum_in   = sum_ff + rd_data_ff;
               last_in  = rd_data_ff;
               state_in = ST_READ;
            end
         end

         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = emit_ptr_ff;
            state_in = ST_EMIT_WR;
         end

         ST_EMIT_WR: begin
            stage_ctl.push = 1'b1;
            item = '{frame_end: (emit_ptr_ff == emit_end_ff), kind: KIND_FRAME,
                     data: rd_data_ff};
            if (stage_sts.push_ok) begin
               if (emit_ptr_ff == emit_end_ff) begin
                  base_in  = split_ff;
                  fill_in  = '0;
                  state_in = ST_READ;
               end else begin
                  emit_ptr_in = emit_ptr_ff + RING_AW'(1);
                  state_in    = ST_EMIT_RD;
               end
            end
         end

         ST_FLUSH: begin
            stage_ctl.flush = 1'b1;
            if (stage_sts.flush_done) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff  <= '0;
         split_ff <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         split_ff <= split_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      last_ff     <= last_in;
      emit_ptr_ff <= emit_ptr_in;
      emit_end_ff <= emit_end_in;
   end

   sfd_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stage_ctl),
      .item       (item),
      .sts        (stage_sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // open frame always spans base..split in the ring
   assert property (@(posedge clock) disable iff (reset)
      RING_AW'(fill_ff) == (split_ff - base_ff))
      else $error("fill count out of step with ring pointers");

   // nothing left to scan when a new byte is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (split_ff == tail_ff))
      else $error("input taken with rescan bytes pending");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_FRAME))
      else $error("frame store overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("frame end on a passthrough byte");
`endif

endmodule

`default_nettype wire
